### hdl/assert_macros.svh
// Assertion macros used by the top level of the reassembly checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hdl/dsrc_pkg.sv
// Types and constants of the datagram sequence and reassembly checker.
`default_nettype none
package dsrc_pkg;

    localparam int unsigned REASSEMBLY_BYTES_DEFAULT = 16384;

    localparam logic [10:0] FULL_FRAG_LEN_RESET     = 11'd1300;
    localparam logic [15:0] MAX_MESSAGE_BYTES_RESET = 16'd16384;
    localparam int unsigned PREFIX_BYTES            = 4;

    localparam logic CFG_FULL_FRAG_LEN     = 1'b0;
    localparam logic CFG_MAX_MESSAGE_BYTES = 1'b1;

    typedef enum logic [2:0] {
        ST_WHOLE       = 3'd0,
        ST_REASSEMBLED = 3'd1,
        ST_STALE       = 3'd2,
        ST_GAP         = 3'd3,
        ST_ILLEGAL     = 3'd4,
        ST_PENDING     = 3'd5,
        ST_OVERSIZE    = 3'd6
    } status_t;

    typedef struct packed {
        logic [31:0] sequence_word;
        logic [15:0] fragment_start;
        logic [15:0] fragment_bytes;
        logic [10:0] payload_bytes;
    } hdr_t;

    typedef struct packed {
        logic [10:0] full_frag_len;
        logic [15:0] max_message_bytes;
    } cfg_t;

    typedef struct packed {
        logic        deliver;
        status_t     status;
        logic [30:0] dropped_count;
        logic [13:0] write_offset;
        logic [14:0] message_bytes;
    } result_t;

endpackage
`default_nettype wire

### hdl/datagram_sequence_reassembly_check_top.sv
// Top level of the datagram sequence and fragment reassembly checker.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid / s_ready  sequence_word, fragment_start,
//                                          fragment_bytes, payload_bytes
//  m_        out        m_valid / m_ready  deliver, status, dropped_count,
//                                          write_offset, message_bytes
//  cfg_      in         cfg_wr_en          cfg_addr, cfg_wr_data
//
// One header per cycle while the m_ side does not stall. A transfer in loads the
// input register; the header then passes the single decision stage into the
// result register, from which the result transfers out on the m_ side.
// Reset clears the sequence state and loads the register defaults; no sweep.
// A stalled m_ side holds the result register; s_ready drops only when both
// the input and the result register are occupied and m_ready is low.
`default_nettype none
`include "assert_macros.svh"
module datagram_sequence_reassembly_check_top #(
    parameter int unsigned REASSEMBLY_BYTES = dsrc_pkg::REASSEMBLY_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_sequence_word,
    input  wire logic [15:0] s_fragment_start,
    input  wire logic [15:0] s_fragment_bytes,
    input  wire logic [10:0] s_payload_bytes,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_deliver,
    output logic [2:0]       m_status,
    output logic [30:0]      m_dropped_count,
    output logic [13:0]      m_write_offset,
    output logic [14:0]      m_message_bytes,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wr_data
);

    dsrc_pkg::cfg_t    cfg_reg;
    dsrc_pkg::hdr_t    hdr_reg;
    logic              in_valid_reg;
    dsrc_pkg::result_t result_reg;
    dsrc_pkg::result_t res;
    logic              out_valid_reg;
    logic              advance;
    logic              fire;

    assign advance = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_frag_len     <= dsrc_pkg::FULL_FRAG_LEN_RESET;
            cfg_reg.max_message_bytes <= dsrc_pkg::MAX_MESSAGE_BYTES_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dsrc_pkg::CFG_FULL_FRAG_LEN: begin
                    cfg_reg.full_frag_len <= cfg_wr_data[10:0];
                end
                dsrc_pkg::CFG_MAX_MESSAGE_BYTES: begin
                    cfg_reg.max_message_bytes <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hdr_reg.sequence_word  <= s_sequence_word;
            hdr_reg.fragment_start <= s_fragment_start;
            hdr_reg.fragment_bytes <= s_fragment_bytes;
            hdr_reg.payload_bytes  <= s_payload_bytes;
        end
    end

    dsrc_check #(
        .REASSEMBLY_BYTES(REASSEMBLY_BYTES)
    ) u_check (
        .aclk   (aclk),
        .aresetn(aresetn),
        .fire   (fire),
        .hdr    (hdr_reg),
        .cfg    (cfg_reg),
        .res    (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    // hold the result while the m_ side stalls
    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= res;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_deliver       = result_reg.deliver;
    assign m_status        = result_reg.status;
    assign m_dropped_count = result_reg.dropped_count;
    assign m_write_offset  = result_reg.write_offset;
    assign m_message_bytes = result_reg.message_bytes;

    `ASSERT_IMPLY(a_deliver_status, aclk, aresetn, m_valid && m_deliver,
        (m_status == dsrc_pkg::ST_WHOLE) || (m_status == dsrc_pkg::ST_REASSEMBLED),
        "deliver with a non-delivering status")
    `ASSERT_IMPLY(a_stale_zero, aclk, aresetn, m_valid && (m_status == dsrc_pkg::ST_STALE),
        (m_dropped_count == 31'd0) && (m_message_bytes == 15'd0) && !m_deliver,
        "stale result carries data")
    `ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready,
        "input stalled with empty result register")
    `ASSERT_NEXT(a_transfer_kept, aclk, aresetn, s_valid && s_ready && m_valid && !m_ready,
        m_valid, "pending result lost after transfer in")

endmodule
`default_nettype wire

### hdl/dsrc_check.sv
// Sequence state and per-header decision logic of the reassembly checker.
`default_nettype none
module dsrc_check #(
    parameter int unsigned REASSEMBLY_BYTES = dsrc_pkg::REASSEMBLY_BYTES_DEFAULT
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire dsrc_pkg::hdr_t   hdr,
    input  wire dsrc_pkg::cfg_t   cfg,
    output dsrc_pkg::result_t     res
);

    localparam int AB_W = $clog2(REASSEMBLY_BYTES + 1);
    localparam int CW   = (AB_W > 16) ? AB_W : 16;
    localparam int EW   = CW + 2;

    logic [30:0]     last_seq_reg, last_seq_next;
    logic [30:0]     asm_seq_reg, asm_seq_next;
    logic [AB_W-1:0] ab_reg, ab_next;

    logic [30:0]   seq;
    logic          frag;
    logic          stale;
    logic [30:0]   dropped;
    logic [EW-1:0] cur_ab;
    logic [EW-1:0] sum;
    logic          gap;
    logic          illegal;
    logic          pending;
    logic          oversize;

    always_comb begin
        seq     = hdr.sequence_word[30:0];
        frag    = hdr.sequence_word[31];
        stale   = (seq <= last_seq_reg);
        dropped = seq - last_seq_reg - 31'd1;
        // a new fragment sequence restarts the buffer before the gap and length checks
        cur_ab  = (seq != asm_seq_reg) ? '0 : EW'(ab_reg);
        sum     = cur_ab + EW'(hdr.fragment_bytes);
        gap     = (EW'(hdr.fragment_start) != cur_ab);
        illegal = (hdr.fragment_bytes > {5'd0, hdr.payload_bytes})
               || (sum > EW'(REASSEMBLY_BYTES));
        pending = (hdr.fragment_bytes == {5'd0, cfg.full_frag_len});
        oversize = (sum + EW'(dsrc_pkg::PREFIX_BYTES)) > EW'(cfg.max_message_bytes);

        last_seq_next     = last_seq_reg;
        asm_seq_next      = asm_seq_reg;
        ab_next           = ab_reg;
        res.deliver       = 1'b0;
        res.status        = dsrc_pkg::ST_STALE;
        res.dropped_count = '0;
        res.write_offset  = '0;
        res.message_bytes = '0;

        if (!stale) begin
            res.dropped_count = dropped;
            if (!frag) begin
                last_seq_next     = seq;
                res.deliver       = 1'b1;
                res.status        = dsrc_pkg::ST_WHOLE;
                res.message_bytes = {4'd0, hdr.payload_bytes};
            end else begin
                asm_seq_next = seq;
                ab_next      = cur_ab[AB_W-1:0];
                if (gap) begin
                    res.status = dsrc_pkg::ST_GAP;
                end else if (illegal) begin
                    res.status = dsrc_pkg::ST_ILLEGAL;
                end else begin
                    res.write_offset = cur_ab[13:0];
                    if (pending) begin
                        ab_next    = sum[AB_W-1:0];
                        res.status = dsrc_pkg::ST_PENDING;
                    end else if (oversize) begin
                        // keep the bytes: later fragments of this message continue from their end
                        ab_next    = sum[AB_W-1:0];
                        res.status = dsrc_pkg::ST_OVERSIZE;
                    end else begin
                        ab_next           = '0;
                        res.deliver       = 1'b1;
                        res.status        = dsrc_pkg::ST_REASSEMBLED;
                        res.message_bytes = sum[14:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_seq_reg <= '0;
            asm_seq_reg  <= '0;
            ab_reg       <= '0;
        end else if (fire) begin
            last_seq_reg <= last_seq_next;
            asm_seq_reg  <= asm_seq_next;
            ab_reg       <= ab_next;
        end
    end

endmodule
`default_nettype wire

### dv/reassembly_result_checker.sv
// Checker that predicts and compares every result of the reassembly checker.
`default_nettype none
module reassembly_result_checker #(
    parameter int unsigned REASSEMBLY_BYTES = dsrc_pkg::REASSEMBLY_BYTES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [31:0] s_sequence_word,
    input  wire logic [15:0] s_fragment_start,
    input  wire logic [15:0] s_fragment_bytes,
    input  wire logic [10:0] s_payload_bytes,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_deliver,
    input  wire logic [2:0]  m_status,
    input  wire logic [30:0] m_dropped_count,
    input  wire logic [13:0] m_write_offset,
    input  wire logic [14:0] m_message_bytes,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wr_data,
    output int               fail_count,
    output int               pending_count
);

    logic [10:0] frag_size;
    logic [15:0] max_msg_bytes;
    logic [30:0] last_seq;
    logic [30:0] asm_seq;
    logic [14:0] asm_bytes;

    dsrc_pkg::result_t expected_results[$];
    dsrc_pkg::result_t exp_r;
    int                errors = 0;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Advance the sequence and reassembly state by one header.
    function automatic dsrc_pkg::result_t reassembly_outcome(input logic [31:0] word,
                                                             input logic [15:0] fstart,
                                                             input logic [15:0] flen,
                                                             input logic [10:0] payload);
        dsrc_pkg::result_t r;
        logic [30:0]       seq;
        int unsigned       total;
        r        = '0;
        r.status = dsrc_pkg::ST_STALE;
        seq      = word[30:0];
        if (seq <= last_seq)
            return r;
        r.dropped_count = seq - last_seq - 31'd1;
        if (!word[31]) begin
            last_seq        = seq;
            r.deliver       = 1'b1;
            r.status        = dsrc_pkg::ST_WHOLE;
            r.message_bytes = 15'(payload);
            return r;
        end
        // a new message sequence restarts assembly before the gap and length checks
        if (seq != asm_seq) begin
            asm_seq   = seq;
            asm_bytes = '0;
        end
        if (32'(fstart) != 32'(asm_bytes)) begin
            r.status = dsrc_pkg::ST_GAP;
            return r;
        end
        total = 32'(asm_bytes) + 32'(flen);
        if (32'(flen) > 32'(payload) || total > REASSEMBLY_BYTES) begin
            r.status = dsrc_pkg::ST_ILLEGAL;
            return r;
        end
        r.write_offset = asm_bytes[13:0];
        asm_bytes      = total[14:0];
        if (32'(flen) == 32'(frag_size)) begin
            r.status = dsrc_pkg::ST_PENDING;
            return r;
        end
        // oversize keeps the assembled bytes
        if (total + dsrc_pkg::PREFIX_BYTES > 32'(max_msg_bytes)) begin
            r.status = dsrc_pkg::ST_OVERSIZE;
            return r;
        end
        r.deliver       = 1'b1;
        r.status        = dsrc_pkg::ST_REASSEMBLED;
        r.message_bytes = total[14:0];
        asm_bytes       = '0;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            frag_size     = dsrc_pkg::FULL_FRAG_LEN_RESET;
            max_msg_bytes = dsrc_pkg::MAX_MESSAGE_BYTES_RESET;
            last_seq      = '0;
            asm_seq       = '0;
            asm_bytes     = '0;
            expected_results.delete();
            pending_count <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    dsrc_pkg::CFG_FULL_FRAG_LEN:     frag_size = cfg_wr_data[10:0];
                    dsrc_pkg::CFG_MAX_MESSAGE_BYTES: max_msg_bytes = cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display({"unexpected result: deliver %0d status %0d dropped %0d",
                                  " offset %0d bytes %0d"},
                                 m_deliver, m_status, m_dropped_count,
                                 m_write_offset, m_message_bytes);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_deliver !== exp_r.deliver || m_status !== exp_r.status ||
                        m_dropped_count !== exp_r.dropped_count ||
                        m_write_offset !== exp_r.write_offset ||
                        m_message_bytes !== exp_r.message_bytes) begin
                        errors++;
                        if (errors <= 10)
                            $display({"result mismatch: expected %0d %0d %0d %0d %0d,",
                                      " got %0d %0d %0d %0d %0d"},
                                     exp_r.deliver, exp_r.status, exp_r.dropped_count,
                                     exp_r.write_offset, exp_r.message_bytes,
                                     m_deliver, m_status, m_dropped_count,
                                     m_write_offset, m_message_bytes);
                    end
                end
            end
            if (s_valid && s_ready)
                expected_results.push_back(reassembly_outcome(s_sequence_word,
                                                              s_fragment_start,
                                                              s_fragment_bytes,
                                                              s_payload_bytes));
            pending_count <= expected_results.size();
        end
        fail_count <= errors;
    end

endmodule
`default_nettype wire

### dv/testbench.sv
// Top of the testbench: clock, reset, header and config stimulus, final verdict.
`default_nettype none
module testbench;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_sequence_word = '0;
    logic [15:0] s_fragment_start = '0;
    logic [15:0] s_fragment_bytes = '0;
    logic [10:0] s_payload_bytes = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_deliver;
    logic [2:0]  m_status;
    logic [30:0] m_dropped_count;
    logic [13:0] m_write_offset;
    logic [14:0] m_message_bytes;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [15:0] cfg_wr_data = '0;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int items_sent = 0;
    int long_asked = 0;
    int long_done = 0;
    bit s_idle_on = 1'b1;
    bit m_idle_on = 1'b1;

    // sequence bookkeeping used only to shape the stimulus
    int unsigned next_seq;
    int unsigned last_whole;
    int unsigned open_seq;
    int          cur_fs;

    datagram_sequence_reassembly_check_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sequence_word  (s_sequence_word),
        .s_fragment_start (s_fragment_start),
        .s_fragment_bytes (s_fragment_bytes),
        .s_payload_bytes  (s_payload_bytes),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_deliver        (m_deliver),
        .m_status         (m_status),
        .m_dropped_count  (m_dropped_count),
        .m_write_offset   (m_write_offset),
        .m_message_bytes  (m_message_bytes),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data)
    );

    reassembly_result_checker result_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sequence_word  (s_sequence_word),
        .s_fragment_start (s_fragment_start),
        .s_fragment_bytes (s_fragment_bytes),
        .s_payload_bytes  (s_payload_bytes),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_deliver        (m_deliver),
        .m_status         (m_status),
        .m_dropped_count  (m_dropped_count),
        .m_write_offset   (m_write_offset),
        .m_message_bytes  (m_message_bytes),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_wr_data      (cfg_wr_data),
        .fail_count       (fail_count),
        .pending_count    (pending_count)
    );

    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: random stall bursts, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (long_done != long_asked) begin
                m_ready <= 1'b0;
                repeat (80) @(posedge aclk);
                long_done = long_done + 1;
            end else if (m_idle_on && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one header and hold it until the transfer.
    task automatic send_hdr(input logic [31:0] word, input logic [15:0] start,
                            input logic [15:0] len, input logic [10:0] payload);
        if (s_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_sequence_word  <= word;
        s_fragment_start <= start;
        s_fragment_bytes <= len;
        s_payload_bytes  <= payload;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic send_frag(input int unsigned seq, input int start, input int len,
                             input int payload);
        send_hdr({1'b1, seq[30:0]}, start[15:0], len[15:0], payload[10:0]);
    endtask

    // Stop offering and wait until every result has transferred out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_count != 0);
    endtask

    task automatic set_config(input int fs, input int mmb);
        cur_fs      = fs;
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= dsrc_pkg::CFG_FULL_FRAG_LEN;
        cfg_wr_data <= 16'(fs);
        @(posedge aclk);
        cfg_addr    <= dsrc_pkg::CFG_MAX_MESSAGE_BYTES;
        cfg_wr_data <= 16'(mmb);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic int unsigned next_sequence();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            next_seq += 1;
        else if (r < 19)
            next_seq += 1 + $urandom_range(1, 5);
        else
            next_seq += 1 + $urandom_range(6, 100000);
        return next_seq;
    endfunction

    // Occasionally slip a gap or an illegal length into a message.
    task automatic maybe_noise(input int unsigned seq, input int off);
        int p;
        if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0) begin
                send_frag(seq, off ^ (1 << $urandom_range(0, 15)), $urandom_range(0, 65535),
                          $urandom_range(0, 2047));
            end else begin
                p = $urandom_range(0, 2046);
                send_frag(seq, off, $urandom_range(p + 1, 65535), p);
            end
        end
    endtask

    task automatic send_message();
        int unsigned seq;
        int          cap;
        int          nfull;
        int          off;
        int          len;
        if (open_seq > last_whole && $urandom_range(0, 4) == 0)
            seq = open_seq;
        else
            seq = next_sequence();
        open_seq = seq;
        cap = 16384 / cur_fs;
        if (cap > 12)
            cap = 12;
        if ($urandom_range(0, 9) < 7) begin
            nfull = $urandom_range(0, 3);
            if (nfull > cap)
                nfull = cap;
        end else begin
            nfull = $urandom_range(0, cap);
        end
        off = 0;
        for (int i = 0; i < nfull; i++) begin
            maybe_noise(seq, off);
            send_frag(seq, off, cur_fs, $urandom_range(cur_fs, 2047));
            off += cur_fs;
        end
        // now and then abandon the message without its short fragment
        if ($urandom_range(0, 9) != 0) begin
            maybe_noise(seq, off);
            len = $urandom_range(0, cur_fs - 1);
            send_frag(seq, off, len, $urandom_range(len, 2047));
        end
    endtask

    task automatic run_traffic(input int target);
        int start_count;
        int pick;
        start_count = items_sent;
        while (items_sent - start_count < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                last_whole = next_sequence();
                send_hdr({1'b0, last_whole[30:0]}, 16'($urandom), 16'($urandom),
                         11'($urandom));
            end else if (pick < 22) begin
                // stale: sequence at or below the last whole packet
                send_hdr({1'($urandom), 31'($urandom_range(0, last_whole))},
                         16'($urandom), 16'($urandom), 11'($urandom));
            end else if (pick < 25) begin
                send_frag(open_seq, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 2047));
            end else begin
                send_message();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        cur_fs = 1300;

        // reset register values: whole, stale, gap, illegal, pending, reassembly
        send_hdr({1'b0, 31'd1}, 16'd0, 16'd0, 11'd0);
        send_hdr({1'b0, 31'd5}, 16'hFFFF, 16'hFFFF, 11'd2047);
        send_hdr({1'b0, 31'd5}, 16'd0, 16'd0, 11'd1);
        send_frag(3, 0, 10, 10);
        send_frag(7, 0, 1300, 1300);
        send_frag(7, 100, 10, 10);
        send_frag(7, 1300, 200, 100);
        send_frag(7, 1300, 200, 2047);
        send_frag(7, 0, 10, 10);
        send_frag(9, 500, 10, 10);
        send_frag(9, 0, 0, 0);
        wait_drained();

        // fill the reassembly buffer exactly, then overflow it
        set_config(2047, 16384);
        for (int i = 0; i < 8; i++)
            send_frag(12, i * 2047, 2047, 2047);
        send_frag(12, 16376, 8, 8);
        send_frag(12, 16384, 0, 0);
        send_frag(12, 16384, 1, 1);
        wait_drained();

        next_seq   = 12;
        last_whole = 5;
        open_seq   = 12;

        set_config(1300, 16384);
        long_asked <= long_asked + 1;
        run_traffic(350);
        wait_drained();

        set_config(1, 4);
        run_traffic(200);
        wait_drained();

        set_config(2047, 32768);
        long_asked <= long_asked + 1;
        run_traffic(300);
        wait_drained();

        set_config(100, 300);
        run_traffic(300);
        wait_drained();

        set_config($urandom_range(1, 2047), $urandom_range(4, 32768));
        run_traffic(300);
        wait_drained();

        set_config(512, 8192);
        s_idle_on = 1'b0;
        m_idle_on = 1'b0;
        run_traffic(400);

        // top of the sequence space: everything after it is stale
        send_hdr({1'b0, 31'h7FFF_FFFF}, 16'hFFFF, 16'd0, 11'h7FF);
        send_hdr({1'b0, 31'h7FFF_FFFF}, 16'd0, 16'd0, 11'd0);
        send_hdr(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 11'h7FF);
        s_valid <= 1'b0;
        wait_drained();
        repeat (6) @(posedge aclk);

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
`default_nettype wire
